// ===== src/deq_pkg.sv =====
// Shared types for the double-ended queue: action and status codes and the
// request and result structs that travel on the top-level ports.
// Depends on nothing; double_ended_queue imports it.
package deq_pkg;

    typedef enum logic [1:0] {
        ACT_PUSH_REAR  = 2'd0,
        ACT_PUSH_FRONT = 2'd1,
        ACT_POP_FRONT  = 2'd2,
        ACT_POP_REAR   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam int VALUE_W = 32;
    localparam int OCC_W   = 5;

    typedef struct packed {
        t_action                    action;
        logic signed [VALUE_W-1:0]  value_in;
    } t_request;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  value_out;
        t_status                    status;
        logic [OCC_W-1:0]           occupancy;
    } t_result;

endpackage

// ===== src/deq_ram.sv =====
// Simple dual-port synchronous RAM holding the queue entries.
// One write port, one read port with registered read data; no package needed.
module deq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read data is registered: it lands in the cycle after the address.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue: ring-buffer pointer logic around one RAM.
// Depends on deq_pkg and deq_ram.
//
//   channel   | direction | handshake              | payload
//   ----------+-----------+------------------------+------------------------------
//   request   | in        | start high, busy low   | i_request (action, value_in)
//   result    | out       | o_valid, one cycle     | o_result (value_out, status,
//             |           |                        |           occupancy)
//
// Each request is accepted at a clock edge and its result is shown in the cycle
// right after that edge; a new request may be accepted at that same edge, so
// one request per cycle is sustained. The single RAM read port and the
// head/count update set this rate. Reset is synchronous and clears the head
// pointer, the entry count and the result strobe; the RAM contents are left as
// they are. The receiver cannot stall, so busy stays low.
module double_ended_queue #(
    parameter int QUEUE_DEPTH = 16,
    parameter int DATA_WIDTH  = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  deq_pkg::t_request i_request,
    output logic              o_valid,
    output deq_pkg::t_result  o_result
);

    import deq_pkg::*;

    localparam int ADDR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W:0]   DEPTH_X   = (ADDR_W + 1)'(QUEUE_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    // Pointer state: the front entry sits at r_head, the rear entry at
    // r_head + r_count - 1, both taken around the ring.
    logic [ADDR_W-1:0] r_head,  n_head;
    logic [CNT_W-1:0]  r_count, n_count;

    // Result stage. The popped value itself comes out of the RAM read register.
    logic              r_valid;
    logic              r_pop_ok;
    t_status           r_status,  n_status;

    logic              accept;
    logic              n_pop_ok;
    logic              wr_en;
    logic [ADDR_W-1:0] slot;
    logic [ADDR_W-1:0] rear_slot;
    logic [ADDR_W-1:0] free_slot;
    logic [ADDR_W-1:0] head_prev;
    logic [ADDR_W-1:0] head_next;
    logic [ADDR_W:0]   sum_free;
    logic [ADDR_W:0]   sum_rear;
    logic [ADDR_W:0]   sum_next;
    logic [DATA_WIDTH-1:0]        wr_data;
    logic signed [DATA_WIDTH-1:0] rd_data;

    // Requests are never held off, so busy is tied low.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Slot arithmetic. Head and count stay below twice the depth when added,
    // so one compare and subtract brings a sum back onto the ring.
    assign sum_free  = {1'b0, r_head} + (ADDR_W + 1)'(r_count);
    assign free_slot = (sum_free >= DEPTH_X) ? ADDR_W'(sum_free - DEPTH_X)
                                             : ADDR_W'(sum_free);

    assign sum_rear  = {1'b0, r_head} + (ADDR_W + 1)'(r_count) - (ADDR_W + 1)'(1);
    assign rear_slot = (sum_rear >= DEPTH_X) ? ADDR_W'(sum_rear - DEPTH_X)
                                             : ADDR_W'(sum_rear);

    assign sum_next  = {1'b0, r_head} + (ADDR_W + 1)'(1);
    assign head_next = (sum_next >= DEPTH_X) ? ADDR_W'(sum_next - DEPTH_X)
                                             : ADDR_W'(sum_next);

    assign head_prev = (r_head == '0) ? LAST_SLOT : r_head - ADDR_W'(1);

    // Only the low DATA_WIDTH bits of the 32-bit value are kept; a wider entry
    // is filled with zeros above them.
    assign wr_data = DATA_WIDTH'($unsigned(i_request.value_in));

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_DONE;
        n_pop_ok = 1'b0;
        wr_en    = 1'b0;
        slot     = r_head;
        if (accept) begin
            case (i_request.action)
                ACT_PUSH_REAR: begin
                    slot = free_slot;
                    if (r_count == FULL_CNT) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                ACT_PUSH_FRONT: begin
                    slot = head_prev;
                    if (r_count == FULL_CNT) begin
                        n_status = ST_FULL;
                    end else begin
                        wr_en   = 1'b1;
                        n_head  = head_prev;
                        n_count = r_count + CNT_W'(1);
                    end
                end
                ACT_POP_FRONT: begin
                    slot = r_head;
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_pop_ok = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                        // The head stays put when the last entry leaves.
                        if (r_count != CNT_W'(1)) begin
                            n_head = head_next;
                        end
                    end
                end
                ACT_POP_REAR: begin
                    slot = rear_slot;
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_pop_ok = 1'b1;
                        n_count  = r_count - CNT_W'(1);
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // A pop reads at the accept edge and the data is used in the next cycle,
    // while a push writes at its accept edge. A push right after a pop thus
    // cannot disturb the read already captured, and a pop right after a push
    // sees the entry already written, so no forwarding is needed.
    deq_ram #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (slot),
        .i_wr_data (wr_data),
        .i_rd_en   (n_pop_ok),
        .i_rd_addr (slot),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_count  <= '0;
            r_valid  <= 1'b0;
            r_pop_ok <= 1'b0;
            r_status <= ST_DONE;
        end else begin
            r_head   <= n_head;
            r_count  <= n_count;
            r_valid  <= accept;
            r_pop_ok <= n_pop_ok;
            r_status <= n_status;
        end
    end

    // The popped entry is sign-extended from DATA_WIDTH bits, or cut to the
    // low 32 bits when entries are wider. Pushes and refusals report zero.
    assign o_valid            = r_valid;
    assign o_result.value_out = r_pop_ok ? VALUE_W'(rd_data) : '0;
    assign o_result.status    = r_status;
    assign o_result.occupancy = OCC_W'(r_count);

    a_count_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count exceeds the queue depth");

    a_head_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= LAST_SLOT)
        else $error("head pointer is off the ring");

    a_one_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && accept) |=> o_valid)
        else $error("accepted request produced no result");

    a_full_refusal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == ST_FULL) |-> (r_count == FULL_CNT && !r_pop_ok))
        else $error("push refused while the queue is not full");

    a_empty_refusal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_status == ST_EMPTY) |-> (r_count == '0 && !r_pop_ok))
        else $error("pop refused while the queue holds entries");

endmodule
